@@ rtl/core/mcdt_pkg.sv @@
package mcdt_pkg;

    localparam int CHANNELS       = 6;
    localparam int THUMB_CHANNELS = 4;
    localparam int CPD_LOG2       = 2;
    localparam int COUNTS_PER_DETENT = 1 << CPD_LOG2;

    localparam int FUNC_W   = 2;
    localparam int CH_W     = 3;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int COUNT_W  = 16;
    localparam int POS_W    = 8;
    localparam int DET_W    = 8;
    localparam int RES_W    = CPD_LOG2 + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DET_W;

    localparam logic [DET_W-1:0] DET_THUMB_RST = 8'd24;
    localparam logic [DET_W-1:0] DET_FACE_RST  = 8'd12;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_SET    = 2'd1,
        FUNC_READ   = 2'd2
    } func_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DETENTS_THUMB     = 1'b0,
        REG_DETENTS_FACEPLATE = 1'b1
    } cfg_reg_e;

    typedef struct packed {
        logic [COUNT_W-1:0]      last_sample;
        logic signed [RES_W-1:0] residual;
        logic [POS_W-1:0]        position;
        logic                    pending;
    } chan_state_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [CH_W-1:0]    channel;
        logic [COUNT_W-1:0] raw_count;
        logic [POS_W-1:0]   new_position;
    } req_item_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             change_flag;
        logic             moved;
    } rsp_item_t;

    function automatic logic is_thumb(input logic [CH_W-1:0] ch);
        is_thumb = {1'b0, ch} < (CH_W + 1)'(THUMB_CHANNELS);
    endfunction

    function automatic logic is_valid_ch(input logic [CH_W-1:0] ch);
        is_valid_ch = {1'b0, ch} < (CH_W + 1)'(CHANNELS);
    endfunction

    function automatic chan_state_t reset_state(input logic [CH_W-1:0] ch);
        chan_state_t s;
        s = '0;
        s.position = is_thumb(ch) ? POS_W'(DET_THUMB_RST >> 1) : POS_W'(DET_FACE_RST >> 1);
        reset_state = s;
    endfunction

endpackage

@@ rtl/core/mcdt_if.sv @@
interface mcdt_req_if
    import mcdt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [CH_W-1:0]    channel;
    logic [COUNT_W-1:0] raw_count;
    logic [POS_W-1:0]   new_position;

    modport source (output valid, func, channel, raw_count, new_position, input ready);
    modport sink   (input valid, func, channel, raw_count, new_position, output ready);
endinterface

interface mcdt_rsp_if
    import mcdt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;
    logic             change_flag;
    logic             moved;

    modport source (output valid, position, change_flag, moved, input ready);
    modport sink   (input valid, position, change_flag, moved, output ready);
endinterface

@@ rtl/core/mcdt_calc.sv @@
module mcdt_calc
    import mcdt_pkg::*;
(
    input  func_e              func,
    input  logic [COUNT_W-1:0] raw_count,
    input  logic [POS_W-1:0]   new_position,
    input  logic [DET_W-1:0]   det,
    input  chan_state_t        cur,
    output chan_state_t        nxt,
    output rsp_item_t          result
);

    localparam int SUM_W = COUNT_W + 2;
    localparam int P_W   = SUM_W + 1;

    logic [COUNT_W-1:0]      diff;
    logic signed [COUNT_W-1:0] diff_s;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] bias;
    logic signed [SUM_W-1:0] quot;
    logic signed [SUM_W-1:0] rem;
    logic signed [P_W-1:0]   pos_sum;
    logic [DET_W-1:0]        limit;
    logic [POS_W-1:0]        clamped;
    logic [POS_W-1:0]        set_pos;
    logic                    moved;
    logic                    flag_out;

    always_comb
    begin
        diff    = raw_count - cur.last_sample;
        diff_s  = $signed(diff);
        sum     = SUM_W'(diff_s) + SUM_W'(cur.residual);
        bias    = sum[SUM_W-1] ? SUM_W'(COUNTS_PER_DETENT - 1) : '0;
        quot    = (sum + bias) >>> CPD_LOG2;
        rem     = sum - (quot <<< CPD_LOG2);
        limit   = det - DET_W'(1);
        pos_sum = $signed({{(P_W - POS_W){1'b0}}, cur.position}) + P_W'(quot);
        if (pos_sum < 0)
        begin
            clamped = '0;
        end
        else if (pos_sum > $signed({{(P_W - DET_W){1'b0}}, limit}))
        begin
            clamped = POS_W'(limit);
        end
        else
        begin
            clamped = pos_sum[POS_W-1:0];
        end
        if (det != '0 && new_position > POS_W'(limit))
        begin
            set_pos = POS_W'(limit);
        end
        else
        begin
            set_pos = new_position;
        end
    end

    always_comb
    begin
        nxt      = cur;
        moved    = 1'b0;
        flag_out = cur.pending;
        unique case (func)
            FUNC_SAMPLE:
            begin
                nxt.last_sample = raw_count;
                if (diff != '0 && det != '0)
                begin
                    nxt.residual = rem[RES_W-1:0];
                    if (quot != '0)
                    begin
                        nxt.position = clamped;
                    end
                    if (nxt.position != cur.position)
                    begin
                        nxt.pending = 1'b1;
                        moved       = 1'b1;
                    end
                end
                flag_out = nxt.pending;
            end
            FUNC_SET:
            begin
                nxt.position = set_pos;
                nxt.residual = '0;
                nxt.pending  = 1'b1;
                flag_out     = 1'b1;
            end
            FUNC_READ:
            begin
                nxt.pending = 1'b0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        result.position    = nxt.position;
        result.change_flag = flag_out;
        result.moved       = moved;
    end

endmodule

@@ rtl/core/multi_channel_detent_tracker_top.sv @@
// Channel  Dir  Payload                                   Transaction
// req      in   func, channel, raw_count, new_position    valid && ready
// rsp      out  position, change_flag, moved              valid && ready
// cfg      in   cfg_index, cfg_data                       cfg_we
//
// One transaction per cycle sustained while rsp accepts; a result follows its request through
// the input register, then the per-channel state update and result register.
// Per-channel state sits in flip-flops, read and written once per cycle, so an item
// sees everything left by the item before it.
// Reset clears all per-channel state at once; positions start at half the reset detent counts.
// A stalled rsp holds the result register; req keeps one more transaction in its
// input register, then drops ready.
module multi_channel_detent_tracker_top
    import mcdt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    mcdt_req_if.sink              req,
    mcdt_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic              req_valid_reg;
    req_item_t         req_reg;
    logic              rsp_valid_reg;
    rsp_item_t         rsp_reg;
    logic [DET_W-1:0]  thumb_reg;
    logic [DET_W-1:0]  face_reg;
    chan_state_t       state_reg [CHANNELS];

    logic              advance;
    logic              fire;
    logic              ch_valid;
    logic [CH_IDX_W-1:0] idx;
    logic [DET_W-1:0]  det;
    chan_state_t       cur;
    chan_state_t       nxt;
    rsp_item_t         calc_result;
    rsp_item_t         rsp_next;

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign fire      = req_valid_reg && advance;
    assign req.ready = !req_valid_reg || advance;

    assign ch_valid = is_valid_ch(req_reg.channel);
    assign idx      = ch_valid ? req_reg.channel[CH_IDX_W-1:0] : '0;
    assign det      = is_thumb(req_reg.channel) ? thumb_reg : face_reg;
    assign cur      = state_reg[idx];
    assign rsp_next = ch_valid ? calc_result : '0;

    mcdt_calc u_calc (
        .func         (func_e'(req_reg.func)),
        .raw_count    (req_reg.raw_count),
        .new_position (req_reg.new_position),
        .det          (det),
        .cur          (cur),
        .nxt          (nxt),
        .result       (calc_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thumb_reg <= DET_THUMB_RST;
            face_reg  <= DET_FACE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_DETENTS_THUMB:     thumb_reg <= cfg_data[DET_W-1:0];
                REG_DETENTS_FACEPLATE: face_reg  <= cfg_data[DET_W-1:0];
                default:               thumb_reg <= thumb_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                req_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= req_valid_reg;
            end
        end
    end

    // hold payloads while stalled
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg.func         <= req.func;
            req_reg.channel      <= req.channel;
            req_reg.raw_count    <= req.raw_count;
            req_reg.new_position <= req.new_position;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                state_reg[i] <= reset_state(CH_W'(i));
            end
        end
        else if (fire && ch_valid)
        begin
            state_reg[idx] <= nxt;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.position    = rsp_reg.position;
    assign rsp.change_flag = rsp_reg.change_flag;
    assign rsp.moved       = rsp_reg.moved;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !ch_valid |=> rsp.position == '0 && !rsp.change_flag && !rsp.moved)
        else $error("invalid channel produced nonzero result");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.moved |-> rsp.change_flag)
        else $error("movement without change flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && ch_valid && req_reg.func == FUNC_SET |=> rsp.change_flag)
        else $error("set transaction did not raise change flag");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && ch_valid && req_reg.func == FUNC_SET && det != '0
        |=> rsp.position < $past(det))
        else $error("set position not clamped");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && req_reg.func != FUNC_SAMPLE |=> !rsp.moved)
        else $error("moved raised on non-sample transaction");
`endif

endmodule
